/* hw/rtl/kv_request_parser_assert.svh */
// Assertion macros for the request parser
`ifndef KV_REQUEST_PARSER_ASSERT_SVH
`define KV_REQUEST_PARSER_ASSERT_SVH
// same-cycle implication
`define KVRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define KVRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hw/rtl/kvrp_pkg.sv */
// Package for the request parser: word types, command table, codes
`timescale 1ns / 1ps
`default_nettype none
package kvrp_pkg;

  localparam int NameBytes    = 16;
  localparam int PrefixBytes  = 7;
  localparam int CommandCount = 108;
  localparam int NameW        = 8 * NameBytes;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  parse_status;
    logic [6:0]  command_number;
    logic        no_forward;
    logic        quit_flag;
    logic [31:0] key_offset;
    logic [31:0] key_length;
    logic        final_flag;
  } out_word_t;

  typedef enum logic [2:0] {
    RES_NONE, RES_KEY, RES_OK, RES_ERR, RES_INC
  } res_e;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_INC = 2'd2;

  localparam logic [2:0] G_TYPE = 3'd0;
  localparam logic [2:0] G_KEY  = 3'd1;
  localparam logic [2:0] G_ARG1 = 3'd2;
  localparam logic [2:0] G_ARG2 = 3'd3;
  localparam logic [2:0] G_ARG3 = 3'd4;
  localparam logic [2:0] G_ARGN = 3'd5;

  localparam logic [4:0] PH_COUNT = 5'd0;
  localparam logic [4:0] PH_LF    = 5'd1;
  localparam logic [4:0] PH_TYPE  = 5'd2;
  localparam logic [4:0] PH_KEY   = 5'd6;
  localparam logic [4:0] PH_ARG1  = 5'd10;
  localparam logic [4:0] PH_ARG2  = 5'd14;
  localparam logic [4:0] PH_ARG3  = 5'd18;
  localparam logic [4:0] PH_ARGN  = 5'd22;

  localparam logic [3:0] C_Z  = 4'd1;
  localparam logic [3:0] C_0  = 4'd2;
  localparam logic [3:0] C_1  = 4'd3;
  localparam logic [3:0] C_2  = 4'd4;
  localparam logic [3:0] C_3  = 4'd5;
  localparam logic [3:0] C_N  = 4'd6;
  localparam logic [3:0] C_X  = 4'd7;
  localparam logic [3:0] C_KV = 4'd8;
  localparam logic [3:0] C_EV = 4'd9;
  localparam logic [3:0] C_ST = 4'd10;
  localparam logic [1:0] F_NOFWD = 2'b01;
  localparam logic [1:0] F_QUIT  = 2'b10;

  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam logic [8*PrefixBytes-1:0] StreamWord = "streams";

  typedef logic [NameW-1:0] name_tab_t [CommandCount];

  // string literals are right-justified; names are read from the left
  localparam name_tab_t CmdNameRaw = '{
    "xadd", "xack", "xread", "xreadgroup", "get", "set", "ttl", "del", "pttl",
    "decr", "dump", "hdel", "hget", "hlen", "hset", "incr", "llen", "lpop", "lrem",
    "lset", "rpop", "sadd", "spop", "srem", "type", "mget", "mset", "zadd", "zrem",
    "eval", "sort", "ping", "quit", "auth", "hkeys", "hmget", "hmset", "hvals",
    "hscan", "lpush", "ltrim", "rpush", "scard", "sdiff", "setex", "setnx", "smove",
    "sscan", "zcard", "zrank", "zscan", "pfadd", "append", "decrby", "exists",
    "expire", "getbit", "getset", "psetex", "hsetnx", "incrby", "lindex", "lpushx",
    "lrange", "rpushx", "setbit", "sinter", "strlen", "sunion", "zcount", "zrange",
    "zscore", "persist", "pexpire", "hexists", "hgetall", "hincrby", "linsert",
    "zincrby", "evalsha", "restore", "pfcount", "pfmerge", "expireat", "bitcount",
    "getrange", "setrange", "smembers", "zrevrank", "pexpireat", "rpoplpush",
    "sismember", "zrevrange", "zlexcount", "sdiffstore", "incrbyfloat",
    "sinterstore", "srandmember", "sunionstore", "zinterstore", "zunionstore",
    "zrangebylex", "hincrbyfloat", "zrangebyscore", "zremrangebylex",
    "zremrangebyrank", "zremrangebyscore", "zrevrangebyscore"
  };

  localparam logic [5:0] CmdCat [CommandCount] = '{
    {2'b00, C_ST}, {2'b00, C_ST}, {2'b00, C_ST}, {2'b00, C_ST},
    {2'b00, C_0}, {2'b00, C_N}, {2'b00, C_0}, {2'b00, C_X}, {2'b00, C_0},
    {2'b00, C_0}, {2'b00, C_0}, {2'b00, C_N}, {2'b00, C_1}, {2'b00, C_0},
    {2'b00, C_2}, {2'b00, C_0}, {2'b00, C_0}, {2'b00, C_0}, {2'b00, C_2},
    {2'b00, C_2}, {2'b00, C_0}, {2'b00, C_N}, {2'b00, C_0}, {2'b00, C_N},
    {2'b00, C_0}, {2'b00, C_X}, {2'b00, C_KV}, {2'b00, C_N}, {2'b00, C_N},
    {2'b00, C_EV}, {2'b00, C_0}, {F_NOFWD, C_Z}, {F_QUIT, C_Z}, {F_NOFWD, C_0},
    {2'b00, C_0}, {2'b00, C_N}, {2'b00, C_N}, {2'b00, C_0}, {2'b00, C_N},
    {2'b00, C_N}, {2'b00, C_2}, {2'b00, C_N}, {2'b00, C_0}, {2'b00, C_N},
    {2'b00, C_2}, {2'b00, C_1}, {2'b00, C_2}, {2'b00, C_N}, {2'b00, C_0},
    {2'b00, C_1}, {2'b00, C_N}, {2'b00, C_N}, {2'b00, C_1}, {2'b00, C_1},
    {2'b00, C_0}, {2'b00, C_1}, {2'b00, C_1}, {2'b00, C_1}, {2'b00, C_2},
    {2'b00, C_2}, {2'b00, C_1}, {2'b00, C_1}, {2'b00, C_1}, {2'b00, C_2},
    {2'b00, C_1}, {2'b00, C_2}, {2'b00, C_N}, {2'b00, C_0}, {2'b00, C_N},
    {2'b00, C_2}, {2'b00, C_N}, {2'b00, C_1}, {2'b00, C_0},
    {2'b00, C_1}, {2'b00, C_1}, {2'b00, C_0}, {2'b00, C_2},
    {2'b00, C_3}, {2'b00, C_2}, {2'b00, C_EV}, {2'b00, C_2},
    {2'b00, C_0}, {2'b00, C_N}, {2'b00, C_1}, {2'b00, C_N},
    {2'b00, C_2}, {2'b00, C_2}, {2'b00, C_0}, {2'b00, C_1},
    {2'b00, C_1}, {2'b00, C_1}, {2'b00, C_1}, {2'b00, C_N},
    {2'b00, C_2}, {2'b00, C_N}, {2'b00, C_1},
    {2'b00, C_N}, {2'b00, C_N}, {2'b00, C_N},
    {2'b00, C_N}, {2'b00, C_N}, {2'b00, C_N},
    {2'b00, C_2}, {2'b00, C_N}, {2'b00, C_2},
    {2'b00, C_2}, {2'b00, C_2}, {2'b00, C_N}
  };

  function automatic logic [5:0] cmd_cat(input logic [6:0] id);
    logic [5:0] r;
    r = 6'd0;
    if (id >= 7'd1 && 32'(id) <= CommandCount) r = CmdCat[32'(id) - 1];
    return r;
  endfunction

  function automatic int name_len(input logic [NameW-1:0] s);
    int n;
    n = 0;
    for (int k = 0; k < NameBytes; k++) if (s[8*k +: 8] != 8'd0) n = k + 1;
    return n;
  endfunction

  function automatic name_tab_t align_names();
    name_tab_t t;
    for (int i = 0; i < CommandCount; i++)
      t[i] = CmdNameRaw[i] << (8 * (NameBytes - name_len(CmdNameRaw[i])));
    return t;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [31:0] times10(input logic [31:0] x, input logic [7:0] c);
    return (x << 3) + (x << 1) + {28'd0, c[3:0]};
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/kv_request_parser.sv */
// Request parser top level: byte-wide array/bulk request parsing
//
// One input word per clock while in_stall_o is low carries a request byte and
// an end-of-buffer mark. Each byte is parsed in the cycle it is accepted; any
// result it causes (a key position report or the final status) lands in the
// output register, so out_valid_o shows it in the cycle after the accept.
// Throughput is one byte per clock while in_stall_o is low, set by the state update and the output register.
// The command name is matched as it streams in: one compare per table entry on
// each name byte, so no name buffer is kept.
// in_stall_o rises only when the output register holds a word the receiver is
// stalling; the register frees and refills in the same cycle as it drains.
// After the status result, bytes up to the buffer end give no result. The byte
// that carries the end mark returns the parse state, save the name match bits,
// to reset; if no status was given by then, that byte yields an incomplete status.
// Reset (rst_ni low, asynchronous) clears the parse state and the output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "kv_request_parser_assert.svh"
module kv_request_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire kvrp_pkg::in_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output kvrp_pkg::out_word_t     out_word_o
);
  import kvrp_pkg::*;

  localparam name_tab_t CmdName = align_names();

  logic [4:0]  phase_q, phase_d;
  logic [31:0] args_q, args_d, len_q, len_d, skip_q, skip_d;
  logic        tok_q, tok_d, dig_q, dig_d, strm_q, strm_d, fin_q, fin_d;
  logic [31:0] pos_q, pos_d, fstart_q, fstart_d, total_q, total_d, kcnt_q, kcnt_d;
  logic [CommandCount-1:0] match_q, match_d;
  logic [6:0]  cmd_q, cmd_d, cmd_hit;
  logic        out_valid_q;
  out_word_t   out_q, out_d;
  logic        accept;
  res_e        res;
  logic [7:0]  ch, chf;
  logic [4:0]  rel;
  logic [2:0]  grp;
  logic [3:0]  cat;
  logic [5:0]  flg;
  logic [31:0] idx;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign ch   = in_word_i.byte_value;
  assign chf  = fold(ch);
  assign rel  = phase_q - PH_TYPE;
  assign grp  = rel[4:2];
  assign cat  = 4'(cmd_cat(cmd_q));
  assign idx  = len_q - skip_q;

  always_comb begin
    cmd_hit = 7'd0;
    for (int i = CommandCount - 1; i >= 0; i--) begin
      if (match_q[i] && len_q == 32'(name_len(CmdNameRaw[i]))) cmd_hit = 7'(i + 1);
    end
  end

  always_comb begin
    phase_d = phase_q; args_d = args_q; len_d = len_q; skip_d = skip_q;
    tok_d = tok_q; dig_d = dig_q; strm_d = strm_q; fin_d = fin_q;
    pos_d = pos_q + 32'd1; fstart_d = fstart_q; total_d = total_q; kcnt_d = kcnt_q;
    match_d = match_q; cmd_d = cmd_q;
    res = RES_NONE;
    if (!fin_q) begin
      if (phase_q == PH_COUNT) begin
        if (!tok_q) begin
          if (ch != CH_STAR) res = RES_ERR;
          else begin
            tok_d = 1'b1; args_d = 32'd0;
          end
        end else if (ch >= "0" && ch <= "9") begin
          args_d = times10(args_q, ch);
        end else if (ch == CH_CR) begin
          if (args_q == 32'd0) res = RES_ERR;
          else begin
            total_d = args_q; tok_d = 1'b0; phase_d = PH_LF;
          end
        end else res = RES_ERR;
      end else if (phase_q == PH_LF) begin
        if (ch != CH_LF) res = RES_ERR;
        else phase_d = PH_TYPE;
      end else if (grp > G_ARGN) begin
        res = RES_ERR;
      end else begin
        case (rel[1:0])
          2'd0: begin
            if (!tok_q) begin
              if (ch != CH_DOLLAR) res = RES_ERR;
              else begin
                tok_d = 1'b1; len_d = 32'd0; dig_d = 1'b0;
              end
            end else if (ch >= "0" && ch <= "9") begin
              len_d = times10(len_q, ch); dig_d = 1'b1;
            end else if (ch == CH_CR) begin
              if (args_q == 32'd0) res = RES_ERR;
              else if (grp == G_TYPE && len_q == 32'd0) res = RES_ERR;
              else if (grp >= G_ARG1 && !dig_q) res = RES_ERR;
              else begin
                args_d = args_q - 32'd1; tok_d = 1'b0; phase_d = phase_q + 5'd1;
              end
            end else res = RES_ERR;
          end
          2'd1: begin
            if (ch != CH_LF) res = RES_ERR;
            else begin
              skip_d = len_q; fstart_d = pos_q + 32'd1; strm_d = 1'b1;
              kcnt_d = 32'd0; dig_d = 1'b0; match_d = '1;
              phase_d = phase_q + 5'd1;
            end
          end
          2'd2: begin
            if (skip_q != 32'd0) begin
              if (grp == G_TYPE && idx < 32'(NameBytes)) begin
                for (int i = 0; i < CommandCount; i++) begin
                  if (CmdName[i][{~idx[3:0], 3'b000} +: 8] != chf) match_d[i] = 1'b0;
                end
              end
              if (grp == G_ARGN && idx < 32'(PrefixBytes)) begin
                if (StreamWord[8 * (PrefixBytes - 1 - int'(idx[2:0])) +: 8] != chf)
                  strm_d = 1'b0;
              end
              if (grp == G_ARG2 && cat == C_EV) begin
                if (ch >= "0" && ch <= "9") kcnt_d = times10(kcnt_q, ch);
                else dig_d = 1'b1;
              end
              skip_d = skip_q - 32'd1;
            end else if (ch != CH_CR) begin
              res = RES_ERR;
            end else begin
              phase_d = phase_q + 5'd1;
              if (grp == G_TYPE) begin
                cmd_d = (len_q > 32'(NameBytes)) ? 7'd0 : cmd_hit;
                if (cmd_d == 7'd0) res = RES_ERR;
              end else if (grp == G_KEY) begin
                res = RES_KEY;
              end else if (grp == G_ARG2 && cat == C_EV) begin
                if (len_q == 32'd0 || dig_q || kcnt_q == 32'd0) res = RES_ERR;
              end
            end
          end
          default: begin
            if (ch != CH_LF) res = RES_ERR;
            else begin
              case (grp)
                G_TYPE: begin
                  if (cat == C_Z) res = RES_OK;
                  else phase_d = (cat == C_EV || cat == C_ST) ? PH_ARG1 : PH_KEY;
                end
                G_KEY: begin
                  if (cat == C_0) res = (args_q != 32'd0) ? RES_ERR : RES_OK;
                  else if (cat == C_1 || cat == C_2 || cat == C_3) begin
                    if (args_q != 32'(cat - C_0)) res = RES_ERR;
                    else phase_d = PH_ARG1;
                  end else if (cat == C_N || cat == C_X || cat == C_KV || cat == C_EV ||
                               cat == C_ST) begin
                    if (args_q == 32'd0) res = RES_OK;
                    else if (cat == C_KV && !total_q[0]) res = RES_ERR;
                    else if (cat == C_X) phase_d = PH_KEY;
                    else if (cat == C_EV || cat == C_ST) phase_d = PH_ARGN;
                    else phase_d = PH_ARG1;
                  end else res = RES_ERR;
                end
                G_ARG1: begin
                  if (cat == C_1) res = (args_q != 32'd0) ? RES_ERR : RES_OK;
                  else if (cat == C_2 || cat == C_3) begin
                    if (args_q != 32'(cat - C_1)) res = RES_ERR;
                    else phase_d = PH_ARG2;
                  end else if (cat == C_EV) begin
                    if (args_q < 32'd2) res = RES_ERR;
                    else phase_d = PH_ARG2;
                  end else if (cat == C_N || cat == C_KV || cat == C_ST) begin
                    if (args_q == 32'd0) res = RES_OK;
                    else phase_d = (cat == C_KV) ? PH_KEY : PH_ARGN;
                  end else res = RES_ERR;
                end
                G_ARG2: begin
                  if (cat == C_2) res = (args_q != 32'd0) ? RES_ERR : RES_OK;
                  else if (cat == C_3) begin
                    if (args_q != 32'd1) res = RES_ERR;
                    else phase_d = PH_ARG3;
                  end else if (cat == C_N) begin
                    if (args_q == 32'd0) res = RES_OK;
                    else phase_d = PH_ARGN;
                  end else if (cat == C_EV) begin
                    if (args_q < 32'd1) res = RES_ERR;
                    else phase_d = PH_KEY;
                  end else res = RES_ERR;
                end
                G_ARG3: begin
                  if (cat == C_3) res = (args_q != 32'd0) ? RES_ERR : RES_OK;
                  else if (cat == C_N) begin
                    if (args_q == 32'd0) res = RES_OK;
                    else phase_d = PH_ARGN;
                  end else res = RES_ERR;
                end
                default: begin
                  if (cat == C_ST && strm_q && len_q >= 32'(PrefixBytes)) phase_d = PH_KEY;
                  else if (cat == C_N || cat == C_EV || cat == C_ST) begin
                    if (args_q == 32'd0) res = RES_OK;
                    else phase_d = PH_ARGN;
                  end else res = RES_ERR;
                end
              endcase
            end
          end
        endcase
      end
      if (res == RES_OK || res == RES_ERR) fin_d = 1'b1;
    end
    if (in_word_i.end_of_buffer && !fin_d) res = RES_INC;

    flg = cmd_cat(cmd_d);
    out_d.result_kind    = (res != RES_KEY);
    out_d.parse_status   = (res == RES_ERR) ? ST_ERR : (res == RES_INC) ? ST_INC : ST_OK;
    out_d.command_number = cmd_d;
    out_d.no_forward     = flg[4];
    out_d.quit_flag      = flg[5];
    out_d.key_offset     = (res == RES_KEY) ? fstart_d : 32'd0;
    out_d.key_length     = (res == RES_KEY) ? len_d : 32'd0;
    out_d.final_flag     = (res != RES_KEY);

    if (in_word_i.end_of_buffer) begin
      phase_d = PH_COUNT; args_d = '0; len_d = '0; skip_d = '0; tok_d = 1'b0;
      dig_d = 1'b0; strm_d = 1'b0; fin_d = 1'b0; pos_d = '0; fstart_d = '0;
      total_d = '0; kcnt_d = '0; cmd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT; args_q <= '0; len_q <= '0; skip_q <= '0; tok_q <= 1'b0;
      dig_q <= 1'b0; strm_q <= 1'b0; fin_q <= 1'b0; pos_q <= '0; fstart_q <= '0;
      total_q <= '0; kcnt_q <= '0; cmd_q <= '0; match_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d; args_q <= args_d; len_q <= len_d; skip_q <= skip_d;
        tok_q <= tok_d; dig_q <= dig_d; strm_q <= strm_d; fin_q <= fin_d;
        pos_q <= pos_d; fstart_q <= fstart_d; total_q <= total_d; kcnt_q <= kcnt_d;
        cmd_q <= cmd_d; match_q <= match_d;
      end
      if (accept) out_valid_q <= (res != RES_NONE);
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  `KVRP_ASSERT_NOW(a_final_is_status, out_valid_o && out_word_o.final_flag, out_word_o.result_kind, "final word not a status")
  `KVRP_ASSERT_NOW(a_key_ok, out_valid_o && !out_word_o.result_kind, out_word_o.parse_status == ST_OK && !out_word_o.final_flag, "bad key report")
  `KVRP_ASSERT_NEXT(a_eob_clears, accept && in_word_i.end_of_buffer, phase_q == PH_COUNT && !fin_q && pos_q == 32'd0, "state not cleared at buffer end")

endmodule
`default_nettype wire

/* bench/tb_kv_request_parser.sv */
// Self-checking testbench for kv_request_parser with a built-in request parser predictor
`timescale 1ns / 1ps
module tb_kv_request_parser;
  import kvrp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;

  kv_request_parser dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  localparam string Names [CommandCount] = '{
    "xadd", "xack", "xread", "xreadgroup", "get", "set", "ttl", "del", "pttl",
    "decr", "dump", "hdel", "hget", "hlen", "hset", "incr", "llen", "lpop", "lrem",
    "lset", "rpop", "sadd", "spop", "srem", "type", "mget", "mset", "zadd", "zrem",
    "eval", "sort", "ping", "quit", "auth", "hkeys", "hmget", "hmset", "hvals",
    "hscan", "lpush", "ltrim", "rpush", "scard", "sdiff", "setex", "setnx", "smove",
    "sscan", "zcard", "zrank", "zscan", "pfadd", "append", "decrby", "exists",
    "expire", "getbit", "getset", "psetex", "hsetnx", "incrby", "lindex", "lpushx",
    "lrange", "rpushx", "setbit", "sinter", "strlen", "sunion", "zcount", "zrange",
    "zscore", "persist", "pexpire", "hexists", "hgetall", "hincrby", "linsert",
    "zincrby", "evalsha", "restore", "pfcount", "pfmerge", "expireat", "bitcount",
    "getrange", "setrange", "smembers", "zrevrank", "pexpireat", "rpoplpush",
    "sismember", "zrevrange", "zlexcount", "sdiffstore", "incrbyfloat",
    "sinterstore", "srandmember", "sunionstore", "zinterstore", "zunionstore",
    "zrangebylex", "hincrbyfloat", "zrangebyscore", "zremrangebylex",
    "zremrangebyrank", "zremrangebyscore", "zrevrangebyscore"
  };

  // parser state
  logic [4:0]  phase;
  logic [31:0] args_left, len_acc, skip_left, byte_pos, fstart, total, keycnt;
  logic        tok_open, dig_seen, done;
  logic [7:0]  nbuf [NameBytes];
  logic [55:0] prefix;
  logic [6:0]  cmd_id;

  out_word_t words_due[$];
  in_word_t  pending[$];
  int errors = 0;
  bit sending_done = 0;
  bit hold_rx = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic clear_parser();
    phase = PH_COUNT; args_left = 0; len_acc = 0; skip_left = 0; byte_pos = 0;
    fstart = 0; total = 0; keycnt = 0; tok_open = 0; dig_seen = 0; done = 0;
    prefix = 0; cmd_id = 0;
  endtask

  function automatic logic [3:0] cat_of(logic [6:0] id);
    logic [5:0] c;
    c = (id >= 1 && id <= CommandCount) ? CmdCat[id - 1] : 6'd0;
    return c[3:0];
  endfunction

  function automatic logic [6:0] lookup_name();
    string s;
    bit same;
    if (len_acc > NameBytes) return 0;
    for (int i = 0; i < CommandCount; i++) begin
      s = Names[i];
      if (s.len() != len_acc) continue;
      same = 1;
      for (int k = 0; k < s.len(); k++)
        if (fold(nbuf[k]) != s[k]) same = 0;
      if (same) return 7'(i + 1);
    end
    return 0;
  endfunction

  function automatic bit prefix_streams();
    string w;
    w = "streams";
    for (int i = 0; i < PrefixBytes; i++)
      if (fold(prefix[8*i +: 8]) != w[i]) return 0;
    return 1;
  endfunction

  function automatic res_e after_lf(logic [2:0] g, logic [3:0] c);
    logic [31:0] a;
    a = args_left;
    case (g)
      G_TYPE: begin
        if (c == C_Z) return RES_OK;
        phase = (c == C_EV || c == C_ST) ? PH_ARG1 : PH_KEY;
        return RES_NONE;
      end
      G_KEY: begin
        if (c == C_0) return a != 0 ? RES_ERR : RES_OK;
        if (c == C_1 || c == C_2 || c == C_3) begin
          if (a != 32'(c - C_0)) return RES_ERR;
          phase = PH_ARG1; return RES_NONE;
        end
        if (c == C_N || c == C_X || c == C_KV || c == C_EV || c == C_ST) begin
          if (a == 0) return RES_OK;
          if (c == C_KV && !total[0]) return RES_ERR;
          phase = (c == C_X) ? PH_KEY : (c == C_EV || c == C_ST) ? PH_ARGN : PH_ARG1;
          return RES_NONE;
        end
        return RES_ERR;
      end
      G_ARG1: begin
        if (c == C_1) return a != 0 ? RES_ERR : RES_OK;
        if (c == C_2 || c == C_3) begin
          if (a != 32'(c - C_1)) return RES_ERR;
          phase = PH_ARG2; return RES_NONE;
        end
        if (c == C_EV) begin
          if (a < 2) return RES_ERR;
          phase = PH_ARG2; return RES_NONE;
        end
        if (c == C_N || c == C_KV || c == C_ST) begin
          if (a == 0) return RES_OK;
          phase = (c == C_KV) ? PH_KEY : PH_ARGN; return RES_NONE;
        end
        return RES_ERR;
      end
      G_ARG2: begin
        if (c == C_2) return a != 0 ? RES_ERR : RES_OK;
        if (c == C_3) begin
          if (a != 1) return RES_ERR;
          phase = PH_ARG3; return RES_NONE;
        end
        if (c == C_N) begin
          if (a == 0) return RES_OK;
          phase = PH_ARGN; return RES_NONE;
        end
        if (c == C_EV) begin
          if (a < 1) return RES_ERR;
          phase = PH_KEY; return RES_NONE;
        end
        return RES_ERR;
      end
      G_ARG3: begin
        if (c == C_3) return a != 0 ? RES_ERR : RES_OK;
        if (c == C_N) begin
          if (a == 0) return RES_OK;
          phase = PH_ARGN; return RES_NONE;
        end
        return RES_ERR;
      end
      default: begin
        if (c == C_ST && prefix_streams()) begin
          phase = PH_KEY; return RES_NONE;
        end
        if (c == C_N || c == C_EV || c == C_ST) begin
          if (a == 0) return RES_OK;
          phase = PH_ARGN; return RES_NONE;
        end
        return RES_ERR;
      end
    endcase
  endfunction

  function automatic res_e parse_byte(logic [7:0] ch);
    logic [2:0] g;
    logic [1:0] sub;
    logic [3:0] c;
    logic [31:0] idx;
    c = cat_of(cmd_id);
    if (phase == PH_COUNT) begin
      if (!tok_open) begin
        if (ch != CH_STAR) return RES_ERR;
        tok_open = 1; args_left = 0;
      end else if (is_digit(ch)) args_left = args_left * 10 + 32'(ch - "0");
      else if (ch == CH_CR) begin
        if (args_left == 0) return RES_ERR;
        total = args_left; tok_open = 0; phase = PH_LF;
      end else return RES_ERR;
      return RES_NONE;
    end
    if (phase == PH_LF) begin
      if (ch != CH_LF) return RES_ERR;
      phase = PH_TYPE; return RES_NONE;
    end
    g = 3'((phase - 2) >> 2);
    sub = 2'((phase - 2) & 3);
    if (g > G_ARGN) return RES_ERR;
    case (sub)
      2'd0: begin
        if (!tok_open) begin
          if (ch != CH_DOLLAR) return RES_ERR;
          tok_open = 1; len_acc = 0; dig_seen = 0;
        end else if (is_digit(ch)) begin
          len_acc = len_acc * 10 + 32'(ch - "0"); dig_seen = 1;
        end else if (ch == CH_CR) begin
          if (args_left == 0) return RES_ERR;
          if (g == G_TYPE && len_acc == 0) return RES_ERR;
          if (g >= G_ARG1 && !dig_seen) return RES_ERR;
          args_left--; tok_open = 0; phase++;
        end else return RES_ERR;
        return RES_NONE;
      end
      2'd1: begin
        if (ch != CH_LF) return RES_ERR;
        skip_left = len_acc; fstart = byte_pos + 1;
        prefix = 0; keycnt = 0; dig_seen = 0; phase++;
        return RES_NONE;
      end
      2'd2: begin
        if (skip_left != 0) begin
          idx = len_acc - skip_left;
          if (g == G_TYPE && idx < NameBytes) nbuf[idx] = ch;
          if (g == G_ARGN && idx < PrefixBytes) prefix[8*idx +: 8] = ch;
          if (g == G_ARG2 && c == C_EV) begin
            if (is_digit(ch)) keycnt = keycnt * 10 + 32'(ch - "0");
            else dig_seen = 1;
          end
          skip_left--;
          return RES_NONE;
        end
        if (ch != CH_CR) return RES_ERR;
        phase++;
        if (g == G_TYPE) begin
          cmd_id = lookup_name();
          if (cmd_id == 0) return RES_ERR;
        end else if (g == G_KEY) return RES_KEY;
        else if (g == G_ARG2 && c == C_EV) begin
          if (len_acc == 0 || dig_seen || keycnt == 0) return RES_ERR;
        end
        return RES_NONE;
      end
      default: begin
        if (ch != CH_LF) return RES_ERR;
        return after_lf(g, c);
      end
    endcase
  endfunction

  task automatic predict_word(in_word_t w);
    res_e r;
    out_word_t o;
    logic [5:0] fl;
    r = RES_NONE;
    if (!done) begin
      r = parse_byte(w.byte_value);
      if (r == RES_OK || r == RES_ERR) done = 1;
    end
    byte_pos++;
    if (w.end_of_buffer && !done) r = RES_INC;
    if (r != RES_NONE) begin
      fl = (cmd_id >= 1 && cmd_id <= CommandCount) ? CmdCat[cmd_id - 1] : 6'd0;
      o = '0;
      o.result_kind = (r != RES_KEY);
      o.parse_status = (r == RES_ERR) ? ST_ERR : (r == RES_INC) ? ST_INC : ST_OK;
      o.command_number = cmd_id;
      o.no_forward = fl[4];
      o.quit_flag = fl[5];
      o.key_offset = (r == RES_KEY) ? fstart : 0;
      o.key_length = (r == RES_KEY) ? len_acc : 0;
      o.final_flag = (r != RES_KEY);
      words_due.push_back(o);
    end
    if (w.end_of_buffer) clear_parser();
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // request building
  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) pending.push_back({s[i], 1'b0});
  endtask

  task automatic put_bulk(string s);
    put_str($sformatf("$%0d\r\n", s.len()));
    put_str(s);
    put_str("\r\n");
  endtask

  function automatic string rand_text(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(33, 126)))};
    return s;
  endfunction

  function automatic string case_mix(string s);
    string t;
    t = s;
    for (int i = 0; i < t.len(); i++)
      if ($urandom_range(0, 1) && t[i] >= "a" && t[i] <= "z") t[i] = t[i] - 32;
    return t;
  endfunction

  task automatic end_buffer();
    in_word_t w;
    if (pending.size() == 0) pending.push_back({CH_CR, 1'b1});
    else begin
      w = pending.pop_back();
      w.end_of_buffer = 1'b1;
      pending.push_back(w);
    end
  endtask

  task automatic put_request(string name, int nargs);
    int extra;
    string a;
    put_str($sformatf("*%0d\r\n", nargs + 1));
    put_bulk(case_mix(name));
    for (int i = 0; i < nargs; i++) begin
      case ($urandom_range(0, 5))
        0: a = case_mix("streams");
        1: a = $sformatf("%0d", $urandom_range(1, 3));
        2: a = "";
        default: a = rand_text($urandom_range(1, 9));
      endcase
      put_bulk(a);
    end
    // occasionally trailing junk after the status
    extra = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < extra; i++) pending.push_back({8'($urandom), 1'b0});
    end_buffer();
  endtask

  task automatic put_noise(int n);
    for (int i = 0; i < n; i++) pending.push_back({8'($urandom), 1'($urandom_range(0, 7) == 0)});
    end_buffer();
  endtask

  // input handshake seen at the rising edge
  logic in_taken = 1'b0;
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  // driver
  int drv_cycle = 0;
  always @(negedge clk_i) begin
    drv_cycle <= drv_cycle + 1;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_taken) begin
        predict_word(in_word_i);
        void'(pending.pop_front());
      end
      if (pending.size() != 0 && (drv_cycle % 1000 < 300 || $urandom_range(0, 99) >= 10)) begin
        in_valid_i <= 1'b1;
        in_word_i <= pending[0];
      end else begin
        in_valid_i <= 1'b0;
        if (pending.size() == 0 && !in_valid_i) sending_done <= 1'b1;
      end
    end
  end

  // receiver stall control
  int rx_hold = 0;
  int rx_cycle = 0;
  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle == 400) rx_hold <= 60;
    else if (rx_hold != 0) rx_hold <= rx_hold - 1;
    out_stall_i <= (rx_hold > 1) || (rx_cycle % 1000 >= 300 && $urandom_range(0, 99) < 10);
  end

  // monitor
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (words_due.size() == 0) report("unexpected word", out_word_o, 0);
      else begin
        e = words_due.pop_front();
        if (out_word_o.result_kind != e.result_kind)
          report("result_kind", out_word_o.result_kind, e.result_kind);
        if (out_word_o.parse_status != e.parse_status)
          report("parse_status", out_word_o.parse_status, e.parse_status);
        if (out_word_o.command_number != e.command_number)
          report("command_number", out_word_o.command_number, e.command_number);
        if (out_word_o.no_forward != e.no_forward)
          report("no_forward", out_word_o.no_forward, e.no_forward);
        if (out_word_o.quit_flag != e.quit_flag)
          report("quit_flag", out_word_o.quit_flag, e.quit_flag);
        if (out_word_o.key_offset != e.key_offset)
          report("key_offset", out_word_o.key_offset, e.key_offset);
        if (out_word_o.key_length != e.key_length)
          report("key_length", out_word_o.key_length, e.key_length);
        if (out_word_o.final_flag != e.final_flag)
          report("final_flag", out_word_o.final_flag, e.final_flag);
      end
    end
  end

  initial begin
    int k;
    clear_parser();
    // directed
    put_request("get", 1);
    put_request("ping", 0);
    put_request("quit", 0);
    put_request("auth", 1);
    put_request("mset", 4);
    put_request("del", 3);
    put_request("eval", 3);
    put_str("*3\r\n$4\r\neval\r\n$3\r\nabc\r\n$1\r\n2\r\n"); end_buffer();
    put_str("*2\r\n$5\r\nxread\r\n"); put_bulk("STREAMS"); end_buffer();
    put_str("*2\r\n$17\r\nzrevrangebyscorex\r\n"); end_buffer();
    put_str("*1\r\n$16\r\nZREVRANGEBYSCORE\r\n"); end_buffer();
    put_str("*1x"); end_buffer();
    put_str("*0\r\n"); end_buffer();
    put_str("*1\r\n$0\r\n"); end_buffer();
    put_str("*4294967297\r\n$3\r\nget\r\n$1\r\nk\r\n"); end_buffer();
    pending.push_back({8'hFF, 1'b0}); pending.push_back({8'h00, 1'b1});
    put_str("*2\r\n$3\r\nget\r\n$2\r\nk"); end_buffer();
    // random
    while (pending.size() < 450) begin
      k = $urandom_range(0, 9);
      if (k == 0) put_noise($urandom_range(1, 6));
      else if (k == 1) begin
        put_request(Names[$urandom_range(0, CommandCount - 1)], $urandom_range(0, 5));
        repeat ($urandom_range(1, 20)) void'(pending.pop_back());
        end_buffer();
      end else if (k == 2) begin
        k = $urandom_range(0, CommandCount - 1);
        put_str("*3\r\n"); put_bulk(Names[k]);
        put_bulk(rand_text(2)); put_bulk("streams"); put_bulk(rand_text(1));
        end_buffer();
      end else
        put_request(Names[$urandom_range(0, CommandCount - 1)], $urandom_range(0, 4));
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (sending_done && words_due.size() == 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && words_due.size() == 0) $display("[kv_request_parser] OK");
    else $display("[kv_request_parser] ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("[kv_request_parser] ERROR");
    $finish;
  end

endmodule
